/* design/uce2u8_pkg.sv */
// ----------------------------------------------------------------------------
// uce2u8_pkg: shared definitions for the universal character escape converter
// Holds the scan phase encoding, the character constants and the hex decoder.
// ----------------------------------------------------------------------------
package uce2u8_pkg;

  localparam int unsigned BurstLen = 6;

  localparam logic [7:0] ChBackslash = 8'h5C;
  localparam logic [7:0] ChLowerU    = 8'h75;

  // Scan phase, one-hot.
  typedef enum logic [5:0] {
    PH_IDLE   = 6'b000001,
    PH_BSLASH = 6'b000010,
    PH_U      = 6'b000100,
    PH_D1     = 6'b001000,
    PH_D2     = 6'b010000,
    PH_D3     = 6'b100000
  } phase_e;

  typedef logic [7:0] byte_t;

  typedef struct packed {
    logic       valid;
    logic [3:0] value;
  } hex_t;

  // Decodes one ASCII hex digit in either case.
  function automatic hex_t hex_decode(input logic [7:0] b);
    hex_t h;
    h.valid = 1'b1;
    h.value = 4'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      h.value = 4'(b - 8'h30);
    end else if (b >= 8'h61 && b <= 8'h66) begin
      h.value = 4'(b - 8'h61 + 8'd10);
    end else if (b >= 8'h41 && b <= 8'h46) begin
      h.value = 4'(b - 8'h41 + 8'd10);
    end else begin
      h.valid = 1'b0;
    end
    return h;
  endfunction

endpackage

/* design/universal_char_escape_to_utf8.sv */
// ----------------------------------------------------------------------------
// universal_char_escape_to_utf8: \uXXXX escape to UTF-8 converter
// Replaces backslash-u escapes in a byte stream with their UTF-8 encoding.
// ----------------------------------------------------------------------------
// Usage:
//   Source text enters on the input channel one word (one byte) at a time,
//   with is_final_i marking the last byte of the text. Converted text leaves
//   on the output channel one byte per word, and out_final_o marks the last
//   byte of the whole text. Both channels use valid and stall: a word moves
//   at a rising edge where valid is high and stall is low.
//   Each accepted byte is decoded in the cycle it arrives and its whole group
//   of 0 to 6 result bytes is written into a burst register; the first byte
//   appears on the output in the cycle after acceptance.
//   Throughput is one input byte per cycle while each byte yields at most one
//   result (the usual case for plain text) and the receiver does not stall.
//   A byte that yields a group of several results stalls the input until
//   the group's last byte leaves, as the burst register drains one byte per
//   cycle. A byte that yields no result (a backslash, or a digit of a pending
//   escape) does not stall the input. The next byte is taken in the cycle
//   that the last byte of a group leaves, so no bubble separates groups.
//   When the receiver stalls, the burst register holds its contents and the
//   input stalls for as long as any byte of the group is still waiting.
//   Reset empties the burst register and returns the scanner to idle.
// ----------------------------------------------------------------------------
module universal_char_escape_to_utf8 (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  input  logic       is_final_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       out_final_o
);

  // Scanner state.
  uce2u8_pkg::phase_e phase_q, phase_d;
  logic [11:0]        code_q, code_d;
  uce2u8_pkg::byte_t  held_q [3];
  uce2u8_pkg::byte_t  held_d [3];

  // Burst register: the result group of one input byte, drained from entry 0.
  uce2u8_pkg::byte_t  burst_q [uce2u8_pkg::BurstLen];
  uce2u8_pkg::byte_t  burst_d [uce2u8_pkg::BurstLen];
  logic [2:0]         rem_q, rem_d;
  logic               fin_q, fin_d;

  logic in_acc;
  logic out_take;

  assign out_valid_o = (rem_q != 3'd0);
  assign out_byte_o  = burst_q[0];
  assign out_final_o = fin_q && (rem_q == 3'd1);
  assign out_take    = out_valid_o && !out_stall_i;

  // The input is free when the burst register is empty or its last byte
  // leaves in this cycle.
  assign in_stall_o = (rem_q > 3'd1) || ((rem_q == 3'd1) && out_stall_i);
  assign in_acc     = in_valid_i && !in_stall_o;

  // Decode of one byte. The result group is a prefix of the pending escape
  // text (backslash, u, held digits) followed by up to three tail bytes.
  uce2u8_pkg::hex_t  hx;
  uce2u8_pkg::byte_t pend [5];
  uce2u8_pkg::byte_t tail [3];
  uce2u8_pkg::byte_t grp  [uce2u8_pkg::BurstLen];
  logic [2:0]        pend_len;
  logic [1:0]        tail_len;
  logic [1:0]        k;
  logic              in_digits;
  logic [15:0]       full_code;
  logic [2:0]        tidx;

  always_comb begin
    hx        = uce2u8_pkg::hex_decode(in_byte_i);
    phase_d   = phase_q;
    code_d    = code_q;
    held_d    = held_q;
    pend_len  = 3'd0;
    tail_len  = 2'd0;
    tail[0]   = in_byte_i;
    tail[1]   = '0;
    tail[2]   = '0;
    k         = 2'd0;
    in_digits = 1'b0;
    full_code = {code_q, hx.value};

    case (phase_q)
      uce2u8_pkg::PH_U:  begin k = 2'd0; in_digits = 1'b1; end
      uce2u8_pkg::PH_D1: begin k = 2'd1; in_digits = 1'b1; end
      uce2u8_pkg::PH_D2: begin k = 2'd2; in_digits = 1'b1; end
      uce2u8_pkg::PH_D3: begin k = 2'd3; in_digits = 1'b1; end
      default: begin
        k         = 2'd0;
        in_digits = 1'b0;
      end
    endcase

    if (phase_q == uce2u8_pkg::PH_BSLASH) begin
      if (in_byte_i == uce2u8_pkg::ChLowerU) begin
        phase_d = uce2u8_pkg::PH_U;
        code_d  = '0;
        if (is_final_i) begin
          pend_len = 3'd2;
        end
      end else begin
        tail[0]  = uce2u8_pkg::ChBackslash;
        tail[1]  = in_byte_i;
        tail_len = 2'd2;
        phase_d  = uce2u8_pkg::PH_IDLE;
      end
    end else if (in_digits && hx.valid) begin
      if (k != 2'd3) begin
        held_d[k] = in_byte_i;
        code_d    = {code_q[7:0], hx.value};
        case (phase_q)
          uce2u8_pkg::PH_U:  phase_d = uce2u8_pkg::PH_D1;
          uce2u8_pkg::PH_D1: phase_d = uce2u8_pkg::PH_D2;
          default:           phase_d = uce2u8_pkg::PH_D3;
        endcase
        // A final byte flushes the escape seen so far, new digit included.
        if (is_final_i) begin
          pend_len = 3'd3 + 3'(k);
        end
      end else begin
        phase_d = uce2u8_pkg::PH_IDLE;
        code_d  = '0;
        if (full_code == 16'd0) begin
          // A zero code point passes through as written.
          pend_len = 3'd5;
          tail_len = 2'd1;
        end else if (full_code < 16'h0080) begin
          tail[0]  = full_code[7:0];
          tail_len = 2'd1;
        end else if (full_code < 16'h0800) begin
          tail[0]  = {3'b110, full_code[10:6]};
          tail[1]  = {2'b10, full_code[5:0]};
          tail_len = 2'd2;
        end else begin
          tail[0]  = {4'b1110, full_code[15:12]};
          tail[1]  = {2'b10, full_code[11:6]};
          tail[2]  = {2'b10, full_code[5:0]};
          tail_len = 2'd3;
        end
      end
    end else begin
      // Idle, or a broken escape: emit what is pending, then scan the byte
      // as if idle.
      if (in_digits) begin
        pend_len = 3'd2 + 3'(k);
        code_d   = '0;
      end
      if (in_byte_i == uce2u8_pkg::ChBackslash) begin
        phase_d = uce2u8_pkg::PH_BSLASH;
        if (is_final_i) begin
          tail_len = 2'd1;
        end
      end else begin
        phase_d  = uce2u8_pkg::PH_IDLE;
        tail_len = 2'd1;
      end
    end

    if (is_final_i) begin
      phase_d = uce2u8_pkg::PH_IDLE;
      code_d  = '0;
    end

    pend[0] = uce2u8_pkg::ChBackslash;
    pend[1] = uce2u8_pkg::ChLowerU;
    pend[2] = held_d[0];
    pend[3] = held_d[1];
    pend[4] = held_d[2];

    for (int i = 0; i < uce2u8_pkg::BurstLen; i++) begin
      tidx = 3'(i) - pend_len;
      if (3'(i) < pend_len) begin
        grp[i] = pend[i % 5];
      end else if (tidx < 3'(tail_len)) begin
        grp[i] = tail[tidx[1:0]];
      end else begin
        grp[i] = '0;
      end
    end
  end

  // Burst register update: load a new group, or shift out one byte.
  always_comb begin
    burst_d = burst_q;
    rem_d   = rem_q;
    fin_d   = fin_q;
    if (in_acc) begin
      burst_d = grp;
      rem_d   = pend_len + 3'(tail_len);
      fin_d   = is_final_i;
    end else if (out_take) begin
      for (int i = 0; i < uce2u8_pkg::BurstLen - 1; i++) begin
        burst_d[i] = burst_q[i + 1];
      end
      rem_d = rem_q - 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= uce2u8_pkg::PH_IDLE;
      code_q  <= '0;
      rem_q   <= '0;
      fin_q   <= 1'b0;
    end else begin
      if (in_acc) begin
        phase_q <= phase_d;
        code_q  <= code_d;
      end
      rem_q <= rem_d;
      fin_q <= fin_d;
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      held_q <= held_d;
    end
    burst_q <= burst_d;
  end

endmodule

/* verif/tb_universal_char_escape_to_utf8.sv */
// ----------------------------------------------------------------------------
// tb_universal_char_escape_to_utf8: self-checking bench for the escape converter
// Streams source text with backslash-u escapes into the block, predicts the
// converted UTF-8 text byte by byte and checks every word that leaves it.
// ----------------------------------------------------------------------------
module tb_universal_char_escape_to_utf8;

  // A few ASCII characters used to build hex digits and plain text.
  localparam uce2u8_pkg::byte_t ChDigit0 = 8'h30;
  localparam uce2u8_pkg::byte_t ChLowerA = 8'h61;
  localparam uce2u8_pkg::byte_t ChUpperA = 8'h41;

  // Limits of the run. The worst correct run (every word a six-byte group,
  // every output word behind the longest random stall) stays far below the
  // cycle limit.
  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned HoldCycles  = 160;
  localparam int unsigned DrainCycles = 8;

  // One expected word of converted text.
  typedef struct packed {
    uce2u8_pkg::byte_t data;
    logic              last;
  } utf8_word_t;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  logic [7:0] in_byte_i;
  logic       is_final_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic [7:0] out_byte_o;
  logic       out_final_o;

  // Converted text still owed by the block, oldest first.
  utf8_word_t expected_text[$];

  // Shadow copy of the scanner state, kept by the predictor.
  uce2u8_pkg::phase_e scan_st;
  uce2u8_pkg::byte_t  held_dig[3];
  logic [15:0]        code_acc;

  // Run controls shared between the test tasks and the traffic processes.
  bit jitter_on;
  bit hold_request;

  int unsigned err_count;
  int unsigned words_in;
  int unsigned words_out;
  int unsigned escapes_done;

  universal_char_escape_to_utf8 dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_byte_i   (in_byte_i),
    .is_final_i  (is_final_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_byte_o  (out_byte_o),
    .out_final_o (out_final_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Value of an ASCII hex digit in either case, or -1 for any other byte.
  function automatic int hex_nibble(input uce2u8_pkg::byte_t b);
    if (b >= 8'h30 && b <= 8'h39) return int'(b - 8'h30);
    if (b >= 8'h61 && b <= 8'h66) return int'(b - 8'h61) + 10;
    if (b >= 8'h41 && b <= 8'h46) return int'(b - 8'h41) + 10;
    return -1;
  endfunction

  // Number of hex digits already held in a given escape phase.
  function automatic int held_count(input uce2u8_pkg::phase_e p);
    case (p)
      uce2u8_pkg::PH_D1: return 1;
      uce2u8_pkg::PH_D2: return 2;
      uce2u8_pkg::PH_D3: return 3;
      default:           return 0;
    endcase
  endfunction

  // A pending escape that is given up goes out as it came in: the
  // backslash, the 'u' and whatever digits were collected.
  function automatic void push_raw_escape(ref uce2u8_pkg::byte_t grp[$],
                                          input int count);
    grp.push_back(uce2u8_pkg::ChBackslash);
    grp.push_back(uce2u8_pkg::ChLowerU);
    for (int i = 0; i < count && i < 3; i++) grp.push_back(held_dig[i]);
  endfunction

  // Runs one accepted input word through the shadow scanner and queues the
  // group of converted bytes it produces.
  task automatic convert_char(input uce2u8_pkg::byte_t b, input logic fin);
    uce2u8_pkg::byte_t grp[$];
    int                nib;
    int                k;
    nib = hex_nibble(b);
    case (scan_st)
      uce2u8_pkg::PH_BSLASH: begin
        if (b == uce2u8_pkg::ChLowerU) begin
          scan_st  = uce2u8_pkg::PH_U;
          code_acc = '0;
        end else begin
          // Any other byte after a backslash passes through uninterpreted.
          grp.push_back(uce2u8_pkg::ChBackslash);
          grp.push_back(b);
          scan_st = uce2u8_pkg::PH_IDLE;
        end
      end
      uce2u8_pkg::PH_U, uce2u8_pkg::PH_D1, uce2u8_pkg::PH_D2, uce2u8_pkg::PH_D3: begin
        k = held_count(scan_st);
        if (nib >= 0) begin
          code_acc = {code_acc[11:0], 4'(nib)};
          if (k < 3) begin
            held_dig[k] = b;
            // The digit phases are one-hot and consecutive.
            scan_st = uce2u8_pkg::phase_e'({scan_st[4:0], 1'b0});
          end else begin
            if (code_acc == 16'h0000) begin
              // A zero code point is left in the text as written.
              push_raw_escape(grp, 3);
              grp.push_back(b);
            end else if (code_acc < 16'h0080) begin
              grp.push_back(code_acc[7:0]);
            end else if (code_acc < 16'h0800) begin
              grp.push_back({3'b110, code_acc[10:6]});
              grp.push_back({2'b10, code_acc[5:0]});
            end else begin
              grp.push_back({4'b1110, code_acc[15:12]});
              grp.push_back({2'b10, code_acc[11:6]});
              grp.push_back({2'b10, code_acc[5:0]});
            end
            escapes_done++;
            scan_st  = uce2u8_pkg::PH_IDLE;
            code_acc = '0;
          end
        end else begin
          // Broken escape: give it back, then rescan the breaking byte.
          push_raw_escape(grp, k);
          code_acc = '0;
          if (b == uce2u8_pkg::ChBackslash) begin
            scan_st = uce2u8_pkg::PH_BSLASH;
          end else begin
            grp.push_back(b);
            scan_st = uce2u8_pkg::PH_IDLE;
          end
        end
      end
      default: begin
        if (b == uce2u8_pkg::ChBackslash) begin
          scan_st = uce2u8_pkg::PH_BSLASH;
        end else begin
          grp.push_back(b);
          scan_st = uce2u8_pkg::PH_IDLE;
        end
      end
    endcase
    if (fin) begin
      // End of text: whatever is still pending is flushed as written.
      if (scan_st == uce2u8_pkg::PH_BSLASH) begin
        grp.push_back(uce2u8_pkg::ChBackslash);
      end else if (scan_st != uce2u8_pkg::PH_IDLE) begin
        push_raw_escape(grp, held_count(scan_st));
      end
      scan_st  = uce2u8_pkg::PH_IDLE;
      code_acc = '0;
    end
    foreach (grp[i]) begin
      expected_text.push_back('{data: grp[i], last: fin && (i == grp.size() - 1)});
    end
  endtask

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------

  // Offers one word and holds it until the block takes it. While jitter is
  // on, the word may be preceded by a burst of idle cycles.
  task automatic send_char(input uce2u8_pkg::byte_t b, input logic fin);
    if (jitter_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_byte_i  <= b;
    is_final_i <= fin;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    convert_char(b, fin);
    words_in++;
  endtask

  // Sends a string, marking its last character final when asked.
  task automatic send_text(input string s, input bit fin_last);
    for (int i = 0; i < s.len(); i++) begin
      send_char(uce2u8_pkg::byte_t'(s[i]), fin_last && (i == s.len() - 1));
    end
  endtask

  // Hex digit for a nibble, in a random letter case.
  function automatic uce2u8_pkg::byte_t hex_char(input logic [3:0] nib);
    if (nib < 4'd10) return ChDigit0 + uce2u8_pkg::byte_t'(nib);
    return ($urandom_range(0, 1) ? ChLowerA : ChUpperA) + uce2u8_pkg::byte_t'(nib) - 8'd10;
  endfunction

  // Builds and sends one random piece of text: complete escapes, the most
  // frequent kind, with values spread over zero and the one, two and three
  // byte encodings, plus broken escapes, backslash pairs and plain bytes.
  // Final marks fall at random, at times in the middle of an escape.
  task automatic send_random_chunk(output int unsigned n_sent);
    uce2u8_pkg::byte_t txt[$];
    logic [15:0]       cp;
    uce2u8_pkg::byte_t brk;
    int unsigned       pick;
    int unsigned       ndig;
    logic              fin;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      case ($urandom_range(0, 5))
        0:       cp = 16'($urandom_range(1, 16'h007F));
        1:       cp = 16'($urandom_range(16'h0080, 16'h07FF));
        2:       cp = 16'h0000;
        default: cp = 16'($urandom);
      endcase
      txt = {uce2u8_pkg::ChBackslash, uce2u8_pkg::ChLowerU};
      for (int i = 0; i < 4; i++) txt.push_back(hex_char(cp[15 - 4 * i -: 4]));
    end else if (pick < 62) begin
      ndig = $urandom_range(0, 3);
      txt = {uce2u8_pkg::ChBackslash, uce2u8_pkg::ChLowerU};
      for (int i = 0; i < ndig; i++) txt.push_back(hex_char(4'($urandom)));
      if ($urandom_range(0, 3) == 0) begin
        brk = uce2u8_pkg::ChBackslash;
      end else begin
        brk = 8'($urandom_range(1, 255));
        while (hex_nibble(brk) >= 0) brk = 8'($urandom_range(1, 255));
      end
      txt.push_back(brk);
    end else if (pick < 72) begin
      txt = {uce2u8_pkg::ChBackslash, 8'($urandom_range(1, 255))};
    end else begin
      for (int i = 0; i < $urandom_range(1, 3); i++) txt.push_back(8'($urandom_range(1, 255)));
    end
    foreach (txt[i]) begin
      fin = ($urandom_range(0, 39) == 0) ||
            ((i == txt.size() - 1) && ($urandom_range(0, 5) == 0));
      send_char(txt[i], fin);
    end
    n_sent = txt.size();
  endtask

  task automatic send_random_text(input int unsigned n_words);
    int unsigned sent;
    int unsigned n;
    sent = 0;
    while (sent < n_words) begin
      send_random_chunk(n);
      sent += n;
    end
  endtask

  // Stops offering words and waits until every expected word has come out.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_text.size() != 0) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Output side
  // ---------------------------------------------------------------------------

  // The receiver stalls in random bursts while jitter is on. On request it
  // holds off for a long stretch so that the block fills up and pushes back
  // on the sender; the request is cleared once the stretch is over.
  initial begin : out_stall_ctl
    int unsigned held_cyc;
    @(posedge rst_ni);
    forever begin
      if (hold_request) begin
        out_stall_i <= 1'b1;
        for (held_cyc = 0; held_cyc < HoldCycles; held_cyc++) @(posedge clk_i);
        hold_request = 1'b0;
      end else if (jitter_on && $urandom_range(0, 5) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 17)) @(posedge clk_i);
      end else begin
        out_stall_i <= 1'b0;
        @(posedge clk_i);
      end
    end
  end

  // Every word taken from the block is matched against the oldest one owed.
  initial begin : utf8_check
    utf8_word_t want;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        words_out++;
        if (expected_text.size() == 0) begin
          err_count++;
          $display("%0t: unexpected word byte=%h final=%b", $time, out_byte_o, out_final_o);
        end else begin
          want = expected_text.pop_front();
          if (out_byte_o !== want.data) begin
            err_count++;
            $display("%0t: out_byte expected %h actual %h", $time, want.data, out_byte_o);
          end
          if (out_final_o !== want.last) begin
            err_count++;
            $display("%0t: out_final expected %b actual %b", $time, want.last, out_final_o);
          end
        end
      end
    end
  end

  // Ends a run that has stopped making progress.
  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("universal_char_escape_to_utf8 test failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Hand-picked text: the byte extremes, a zero value, a three-byte
  // surrogate in mixed case, the two-byte range, an escape broken by a
  // backslash that then forms an uppercase pair, and texts that end in the
  // middle of an escape or right after a backslash.
  task automatic test_directed();
    send_char(8'h01, 1'b0);
    send_char(8'hFF, 1'b0);
    send_text("\\u0000", 1'b0);
    send_text("\\uD8fF", 1'b0);
    send_text("\\u00e9", 1'b0);
    send_text("\\u7\\U", 1'b0);
    send_text("\\u0", 1'b1);
    send_text("\\", 1'b1);
    wait_drained();
  endtask

  // Mixed random text with idling on both sides.
  task automatic test_random_text();
    send_random_text(115);
    wait_drained();
  endtask

  // The receiver holds off while the sender keeps offering text.
  task automatic test_backpressure();
    hold_request = 1'b1;
    send_random_text(20);
    wait_drained();
    while (hold_request) @(posedge clk_i);
  endtask

  // Full rate on both sides to close the run, ending on a final word.
  task automatic test_steady_stream();
    jitter_on = 1'b0;
    send_random_text(40);
    send_char(8'h7E, 1'b1);
    wait_drained();
  endtask

  initial begin
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    in_byte_i    = 8'h20;
    is_final_i   = 1'b0;
    out_stall_i  = 1'b0;
    jitter_on    = 1'b1;
    hold_request = 1'b0;
    err_count    = 0;
    words_in     = 0;
    words_out    = 0;
    escapes_done = 0;
    scan_st      = uce2u8_pkg::PH_IDLE;
    code_acc     = '0;
    foreach (held_dig[i]) held_dig[i] = '0;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_directed();
    test_random_text();
    test_backpressure();
    test_steady_stream();

    repeat (DrainCycles) @(posedge clk_i);
    $display("Sent %0d words of source text and checked %0d words of output,",
             words_in, words_out);
    $display("with %0d escapes converted and a long receiver hold-off.", escapes_done);
    if (err_count == 0) begin
      $display("universal_char_escape_to_utf8 test passed");
    end else begin
      $display("universal_char_escape_to_utf8 test failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
design/uce2u8_pkg.sv
design/universal_char_escape_to_utf8.sv
verif/tb_universal_char_escape_to_utf8.sv
